// File: hdl/mtsp_pkg.sv
// Package: phase, event and reject code types and character constants for the media-type parser.
`timescale 1ns / 1ps
`default_nettype none
package mtsp_pkg;

    // Result queue depth; a power of two of at least two, so the pointers wrap by truncation
    localparam int QDEPTH = 4;

    // Parse phases
    typedef enum logic [3:0] {
        PH_TYPE_FIRST  = 4'd0,
        PH_TYPE        = 4'd1,
        PH_SUB_FIRST   = 4'd2,
        PH_SUB         = 4'd3,
        PH_AFTER_VALUE = 4'd4,
        PH_SEP_SPACES  = 4'd5,
        PH_NAME_LEAD   = 4'd6,
        PH_NAME        = 4'd7,
        PH_VALUE_FIRST = 4'd8,
        PH_TOKEN       = 4'd9,
        PH_QUOTED      = 4'd10,
        PH_QUOTED_ESC  = 4'd11,
        PH_SWALLOW     = 4'd12
    } t_phase;

    // Event kinds on the result channel
    typedef enum logic [2:0] {
        EV_TYPE   = 3'd0,
        EV_SUB    = 3'd1,
        EV_NAME   = 3'd2,
        EV_VALUE  = 3'd3,
        EV_NDONE  = 3'd4,
        EV_VDONE  = 3'd5,
        EV_ACCEPT = 3'd6,
        EV_REJECT = 3'd7
    } t_kind;

    // Reject codes
    localparam logic [3:0] RJ_NONE          = 4'd0;
    localparam logic [3:0] RJ_EMPTY_TYPE    = 4'd1;
    localparam logic [3:0] RJ_NO_SLASH      = 4'd2;
    localparam logic [3:0] RJ_EMPTY_SUBTYPE = 4'd3;
    localparam logic [3:0] RJ_BAD_SEP       = 4'd4;
    localparam logic [3:0] RJ_NO_EQUALS     = 4'd5;
    localparam logic [3:0] RJ_TRUNC_QUOTE   = 4'd6;
    localparam logic [3:0] RJ_BAD_ESCAPE    = 4'd7;
    localparam logic [3:0] RJ_EMPTY_VALUE   = 4'd8;

    // Characters of interest
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // One result item without its last-of-run mark
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [3:0] code;
    } t_event;

    // One queued result item
    typedef struct packed {
        t_event ev;
        logic   last;
    } t_result;

    // ASCII A..Z to lower case, everything else unchanged
    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic t_event mk_event(input t_kind k, input logic [7:0] d,
                                        input logic [3:0] code);
        t_event e;
        e.kind = k;
        e.data = d;
        e.code = code;
        return e;
    endfunction

endpackage
`default_nettype wire

// File: hdl/media_type_stream_parser_top.sv
// Top level: streaming media-type parser with input register, phase machine and result queue.
// Path: a character is held in the input register, and its results are written into the result
//   queue when it is processed; it waits there while the queue has fewer than two free entries.
// Throughput: one input item per cycle while two queue entries are free; items giving two
//   results leave one at a time; a four-entry result queue absorbs them while downstream keeps up.
// Reset (i_rst_n low, synchronous): phase to expecting first type character, escape flag
//   cleared, input register and result queue emptied.
`timescale 1ns / 1ps
`default_nettype none
module media_type_stream_parser_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input channel
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_end_of_text,
    // result channel
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [2:0]      o_event_kind,
    output logic [7:0]      o_out_byte,
    output logic [3:0]      o_reject_code,
    output logic            o_last_of_run
);
    import mtsp_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    // Parse state
    t_phase r_phase, n_phase;
    logic   r_bad_esc, n_bad_esc;

    // Result queue
    t_result        r_q [QDEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;

    logic       proc;
    logic       pop;
    logic [1:0] ev_cnt;
    t_event     ev0, ev1;
    logic [7:0] c;
    logic       e;
    logic [CW-1:0] free_cnt;

    assign c        = r_in_byte;
    assign e        = r_in_end;
    assign free_cnt = CW'(QDEPTH) - r_count;
    assign proc     = r_in_valid && (free_cnt >= CW'(2));
    assign pop      = o_out_valid && i_out_ready;

    assign o_in_ready = !r_in_valid || proc;

    // Input register load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_text_byte;
            r_in_end  <= i_end_of_text;
        end
    end

    // Next phase and escape flag
    always_comb begin
        n_phase   = r_phase;
        n_bad_esc = r_bad_esc;
        if (e) begin
            n_phase = PH_TYPE_FIRST;
        end else begin
            case (r_phase)
                PH_TYPE_FIRST: begin
                    n_phase = (c == CH_SLASH) ? PH_SWALLOW : PH_TYPE;
                end
                PH_TYPE: begin
                    if (c == CH_SLASH) n_phase = PH_SUB_FIRST;
                end
                PH_SUB_FIRST: begin
                    n_phase = (c inside {CH_SPACE, CH_SEMI}) ? PH_SWALLOW : PH_SUB;
                end
                PH_SUB, PH_AFTER_VALUE, PH_TOKEN: begin
                    if (c == CH_SPACE) begin
                        n_phase = PH_SEP_SPACES;
                    end else if (c == CH_SEMI) begin
                        n_phase = PH_NAME_LEAD;
                    end else if (r_phase == PH_AFTER_VALUE) begin
                        n_phase = PH_SWALLOW;
                    end
                end
                PH_SEP_SPACES: begin
                    if (c == CH_SEMI) begin
                        n_phase = PH_NAME_LEAD;
                    end else if (c != CH_SPACE) begin
                        n_phase = PH_SWALLOW;
                    end
                end
                PH_NAME_LEAD, PH_NAME: begin
                    if (c == CH_EQUALS) begin
                        n_phase = PH_VALUE_FIRST;
                    end else if (!(c == CH_SPACE && r_phase == PH_NAME_LEAD)) begin
                        n_phase = PH_NAME;
                    end
                end
                PH_VALUE_FIRST: begin
                    if (c inside {CH_SPACE, CH_SEMI}) begin
                        n_phase = PH_SWALLOW;
                    end else if (c == CH_QUOTE) begin
                        n_bad_esc = 1'b0;
                        n_phase   = PH_QUOTED;
                    end else begin
                        n_phase = PH_TOKEN;
                    end
                end
                PH_QUOTED: begin
                    if (c == CH_BSLASH) begin
                        n_phase = PH_QUOTED_ESC;
                    end else if (c == CH_QUOTE) begin
                        n_phase = r_bad_esc ? PH_SWALLOW : PH_AFTER_VALUE;
                    end
                end
                PH_QUOTED_ESC: begin
                    if (!(c inside {CH_BSLASH, CH_QUOTE})) n_bad_esc = 1'b1;
                    n_phase = PH_QUOTED;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Events for the current item
    always_comb begin
        ev_cnt = 2'd0;
        ev0    = mk_event(EV_ACCEPT, 8'h00, RJ_NONE);
        ev1    = mk_event(EV_ACCEPT, 8'h00, RJ_NONE);
        case (r_phase)
            PH_TYPE_FIRST: begin
                ev_cnt = 2'd1;
                if (e || c == CH_SLASH) ev0 = mk_event(EV_REJECT, 8'h00, RJ_EMPTY_TYPE);
                else                    ev0 = mk_event(EV_TYPE, lower_ascii(c), RJ_NONE);
            end
            PH_TYPE: begin
                if (e) begin
                    ev_cnt = 2'd1;
                    ev0    = mk_event(EV_REJECT, 8'h00, RJ_NO_SLASH);
                end else if (c != CH_SLASH) begin
                    ev_cnt = 2'd1;
                    ev0    = mk_event(EV_TYPE, lower_ascii(c), RJ_NONE);
                end
            end
            PH_SUB_FIRST: begin
                ev_cnt = 2'd1;
                if (e || c inside {CH_SPACE, CH_SEMI}) begin
                    ev0 = mk_event(EV_REJECT, 8'h00, RJ_EMPTY_SUBTYPE);
                end else begin
                    ev0 = mk_event(EV_SUB, lower_ascii(c), RJ_NONE);
                end
            end
            PH_SUB: begin
                if (e) begin
                    ev_cnt = 2'd1;
                end else if (!(c inside {CH_SPACE, CH_SEMI})) begin
                    ev_cnt = 2'd1;
                    ev0    = mk_event(EV_SUB, lower_ascii(c), RJ_NONE);
                end
            end
            PH_AFTER_VALUE: begin
                if (e) begin
                    ev_cnt = 2'd1;
                end else if (!(c inside {CH_SPACE, CH_SEMI})) begin
                    ev_cnt = 2'd1;
                    ev0    = mk_event(EV_REJECT, 8'h00, RJ_BAD_SEP);
                end
            end
            PH_SEP_SPACES: begin
                if (e || !(c inside {CH_SPACE, CH_SEMI})) begin
                    ev_cnt = 2'd1;
                    ev0    = mk_event(EV_REJECT, 8'h00, RJ_BAD_SEP);
                end
            end
            PH_NAME_LEAD, PH_NAME: begin
                if (e) begin
                    ev_cnt = 2'd1;
                    ev0    = mk_event(EV_REJECT, 8'h00, RJ_NO_EQUALS);
                end else if (c == CH_EQUALS) begin
                    ev_cnt = 2'd1;
                    ev0    = mk_event(EV_NDONE, 8'h00, RJ_NONE);
                end else if (!(c == CH_SPACE && r_phase == PH_NAME_LEAD)) begin
                    ev_cnt = 2'd1;
                    ev0    = mk_event(EV_NAME, lower_ascii(c), RJ_NONE);
                end
            end
            PH_VALUE_FIRST: begin
                if (e || c inside {CH_SPACE, CH_SEMI}) begin
                    ev_cnt = 2'd1;
                    ev0    = mk_event(EV_REJECT, 8'h00, RJ_EMPTY_VALUE);
                end else if (c != CH_QUOTE) begin
                    ev_cnt = 2'd1;
                    ev0    = mk_event(EV_VALUE, c, RJ_NONE);
                end
            end
            PH_TOKEN: begin
                ev_cnt = 2'd1;
                if (e) begin
                    // value done, then accept
                    ev_cnt = 2'd2;
                    ev0    = mk_event(EV_VDONE, 8'h00, RJ_NONE);
                end else if (c inside {CH_SPACE, CH_SEMI}) begin
                    ev0 = mk_event(EV_VDONE, 8'h00, RJ_NONE);
                end else begin
                    ev0 = mk_event(EV_VALUE, c, RJ_NONE);
                end
            end
            PH_QUOTED: begin
                if (e) begin
                    ev_cnt = 2'd1;
                    ev0    = mk_event(EV_REJECT, 8'h00, RJ_TRUNC_QUOTE);
                end else if (c == CH_QUOTE) begin
                    ev_cnt = 2'd1;
                    if (r_bad_esc) ev0 = mk_event(EV_REJECT, 8'h00, RJ_BAD_ESCAPE);
                    else           ev0 = mk_event(EV_VDONE, 8'h00, RJ_NONE);
                end else if (c != CH_BSLASH) begin
                    ev_cnt = 2'd1;
                    ev0    = mk_event(EV_VALUE, c, RJ_NONE);
                end
            end
            PH_QUOTED_ESC: begin
                if (e) begin
                    ev_cnt = 2'd1;
                    ev0    = mk_event(EV_REJECT, 8'h00, RJ_TRUNC_QUOTE);
                end else if (c inside {CH_BSLASH, CH_QUOTE}) begin
                    ev_cnt = 2'd1;
                    ev0    = mk_event(EV_VALUE, c, RJ_NONE);
                end
            end
            default: begin
                ev_cnt = 2'd0;
            end
        endcase
    end

    // Phase registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TYPE_FIRST;
            r_bad_esc <= 1'b0;
        end else if (proc) begin
            r_phase   <= n_phase;
            r_bad_esc <= n_bad_esc;
        end
    end

    // Result queue write and read
    always_ff @(posedge i_clk) begin
        if (proc && ev_cnt != 2'd0) begin
            r_q[r_wr_ptr] <= '{ev: ev0, last: (ev_cnt == 2'd1)};
        end
        if (proc && ev_cnt == 2'd2) begin
            r_q[PW'(r_wr_ptr + PW'(1))] <= '{ev: ev1, last: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (proc) begin
                r_wr_ptr <= PW'(r_wr_ptr + PW'(ev_cnt));
            end
            if (pop) begin
                r_rd_ptr <= PW'(r_rd_ptr + PW'(1));
            end
            r_count <= CW'(r_count + (proc ? CW'(ev_cnt) : CW'(0)) - (pop ? CW'(1) : CW'(0)));
        end
    end

    // Head of queue drives the result channel
    assign o_out_valid   = (r_count != '0);
    assign o_event_kind  = r_q[r_rd_ptr].ev.kind;
    assign o_out_byte    = r_q[r_rd_ptr].ev.data;
    assign o_reject_code = r_q[r_rd_ptr].ev.code;
    assign o_last_of_run = r_q[r_rd_ptr].last;

endmodule
`default_nettype wire

// File: hdl/mtsp_checker.sv
// Checker: port-level properties of the media-type parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mtsp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] o_event_kind,
    input wire logic [7:0] o_out_byte,
    input wire logic [3:0] o_reject_code,
    input wire logic       o_last_of_run
);
    import mtsp_pkg::*;

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_event_kind)
            && $stable(o_out_byte) && $stable(o_reject_code) && $stable(o_last_of_run))
        else $error("result changed while stalled");

    // Reject code present exactly on reject results
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_event_kind == EV_REJECT) == (o_reject_code != RJ_NONE)))
        else $error("reject code does not match event kind");

    // Marks carry no byte
    a_mark_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_kind == EV_NDONE || o_event_kind == EV_VDONE
            || o_event_kind == EV_ACCEPT || o_event_kind == EV_REJECT) |-> o_out_byte == 8'h00)
        else $error("mark event carries a byte");

    // Accept and reject always close the run
    a_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_kind == EV_ACCEPT || o_event_kind == EV_REJECT)
            |-> o_last_of_run)
        else $error("verdict not last of run");

    // Type, subtype and name bytes come out lower-cased
    a_lower: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_kind == EV_TYPE || o_event_kind == EV_SUB
            || o_event_kind == EV_NAME) |-> !(o_out_byte >= 8'h41 && o_out_byte <= 8'h5A))
        else $error("upper-case letter in folded field");

endmodule

bind media_type_stream_parser_top mtsp_checker u_mtsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_event_kind  (o_event_kind),
    .o_out_byte    (o_out_byte),
    .o_reject_code (o_reject_code),
    .o_last_of_run (o_last_of_run)
);
`default_nettype wire
